/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Sizes, entry and control types, and the opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int VALUE_WIDTH    = 16;
    localparam int PRIORITY_WIDTH = 16;
    localparam int OCC_WIDTH      = 5;
    localparam int STATUS_WIDTH   = 2;
    localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);

    localparam int S_FIELD_BITS = VALUE_WIDTH + PRIORITY_WIDTH;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = VALUE_WIDTH + PRIORITY_WIDTH + OCC_WIDTH;
    localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]    value;
        logic [PRIORITY_WIDTH-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares it with an incoming entry and shifts toward
// the tail on insertion or toward the head on removal.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  spq_pkg::entry_t     new_entry,
    input  logic                left_gt,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t     entry,
    output logic                gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // The stored entry stays ahead only if it is strictly more urgent.
    assign gt = occupied && (entry_reg.prio > new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!gt)
            begin
                entry_next = left_gt ? new_entry : left_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a chain of sorted cells
// Entries are kept in descending priority order, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_axis channel is an enqueue (tuser = 0) carrying a
// payload and a priority in tdata, or a dequeue (tuser = 1). Every request
// gives exactly one response on the m_axis channel: a status in tuser and
// the dequeued payload, its priority and the occupancy in tdata.
// An enqueue lands behind all entries of strictly higher priority, so equal
// priorities leave newest first. A dequeue on an empty queue reports empty;
// an enqueue on a full queue reports full and the request is dropped.
// The response is registered and appears in the cycle after acceptance. One
// request is taken every cycle while the receiver keeps up: all cells compare
// against the new priority and shift in parallel within the cycle, and the
// response register frees each cycle the receiver takes it.
// Reset empties the queue; the cell storage itself is not cleared.
// When the receiver stalls, the response is held and s_axis_tready drops
// until the response is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: item_value, item_priority
    input  logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: out_value, out_priority, occupancy
    output logic [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [spq_pkg::STATUS_WIDTH-1:0] m_axis_tuser
);
    import spq_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                status_reg;
    status_t                status_next;
    entry_t                 result_reg;
    entry_t                 result_next;
    logic [OCC_WIDTH-1:0]   occ_reg;
    logic [OCC_WIDTH-1:0]   occ_next;

    logic       accept;
    logic       is_deq;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    entry_t     new_entry;

    entry_t     cell_entry [DEPTH];
    logic       cell_gt    [DEPTH];
    logic       cell_occ   [DEPTH];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_deq        = (s_axis_tuser[0] == OP_DEQUEUE);
    assign full          = (count_reg == COUNT_WIDTH'(DEPTH));
    assign empty         = (count_reg == '0);

    assign new_entry.value = s_axis_tdata[VALUE_WIDTH-1:0];
    assign new_entry.prio  = s_axis_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];

    assign ctrl.enq = accept && !is_deq && !full;
    assign ctrl.deq = accept && is_deq && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_gt;

            assign cell_occ[gi] = (count_reg > COUNT_WIDTH'(gi));

            if (gi == 0)
            begin : g_head
                assign left_gt    = 1'b1;
                assign left_entry = new_entry;
            end
            else
            begin : g_body
                assign left_gt    = cell_gt[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[gi]),
                .new_entry   (new_entry),
                .left_gt     (left_gt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        result_next  = result_reg;
        occ_next     = occ_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept)
        begin
            m_valid_next = 1'b1;
            status_next  = STATUS_OK;
            result_next  = '0;
            if (is_deq)
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    result_next = cell_entry[0];
                    count_next  = count_reg - 1'b1;
                end
            end
            else
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            occ_next = OCC_WIDTH'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[VALUE_WIDTH-1:0]                          = result_reg.value;
        m_axis_tdata[VALUE_WIDTH +: PRIORITY_WIDTH]            = result_reg.prio;
        m_axis_tdata[VALUE_WIDTH + PRIORITY_WIDTH +: OCC_WIDTH] = occ_reg;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_WIDTH'(DEPTH))
        else $error("queue count exceeds its depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= COUNT_WIDTH'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
        else $error("head entry is out of priority order");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_deq && full |=> count_reg == COUNT_WIDTH'(DEPTH)
            && status_reg == STATUS_FULL)
        else $error("enqueue on a full queue changed the count");
`endif

endmodule
